// ===== rtl/rjds_pkg.sv =====
package rjds_pkg;

   // command codes
   localparam logic [1:0] OP_ADD      = 2'd0;
   localparam logic [1:0] OP_COMPLETE = 2'd1;
   localparam logic [1:0] OP_LIST     = 2'd2;

   // order modes; the unused code falls back to arrival order
   localparam logic [1:0] MODE_ARRIVAL  = 2'd0;
   localparam logic [1:0] MODE_PRIORITY = 2'd1;
   localparam logic [1:0] MODE_DEADLINE = 2'd2;
   localparam logic [1:0] MODE_RESET    = MODE_PRIORITY;

   // fixed field and counter widths
   localparam int ID_W        = 4;
   localparam int MASK_W      = 16;
   localparam int ARRIVAL_W   = 16;
   localparam int LIST_MAX    = 16;
   localparam int LIST_CNT_W  = $clog2(LIST_MAX);

   typedef struct packed {
      logic [1:0]        opcode;
      logic [ID_W-1:0]   job_id;
      logic [7:0]        job_priority;
      logic [15:0]       job_deadline;
      logic [MASK_W-1:0] depends_on_mask;
   } req_data_type;

   typedef struct packed {
      logic [ID_W-1:0] ready_id;
      logic            ready_valid;
      logic            last_in_list;
   } rsp_data_type;

   // controller to datapath
   typedef struct packed {
      logic add;
      logic complete;
      logic load;
      logic step;
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic last;
   } dp_status_type;

endpackage

// ===== rtl/rjds_ctrl.sv =====
module rjds_ctrl
   import rjds_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  logic [1:0]    req_opcode,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output dp_cmd_type    dp_cmd,
   input  dp_status_type dp_status
);

   typedef enum logic {
      ST_IDLE,
      ST_LIST
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;
   logic      out_free;

   // handshake and command decode
   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;

   assign dp_cmd.add      = accept && (req_opcode == OP_ADD);
   assign dp_cmd.complete = accept && (req_opcode == OP_COMPLETE);
   assign dp_cmd.load     = accept && (req_opcode == OP_LIST);
   assign dp_cmd.step     = (state_ff == ST_LIST) && out_free;

   // next state and output valid
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (dp_cmd.load) begin
               state_in = ST_LIST;
            end
         end
         ST_LIST: begin
            if (dp_cmd.step) begin
               rsp_valid_in = 1'b1;
               if (dp_status.last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== rtl/rjds_datapath.sv =====
module rjds_datapath
   import rjds_pkg::*;
#(
   parameter int JOB_SLOTS     = 16,
   parameter int PRIORITY_BITS = 8,
   parameter int DEADLINE_BITS = 16
) (
   input  logic          clock,
   input  logic          reset,
   input  req_data_type  req_data,
   input  logic          csr_we,
   input  logic [1:0]    csr_wdata,
   input  dp_cmd_type    dp_cmd,
   output dp_status_type dp_status,
   output rsp_data_type  rsp_data
);

   localparam int SLOT_W = $clog2(JOB_SLOTS);
   localparam int LEAVES = 1 << SLOT_W;
   localparam int NODES  = 2 * LEAVES - 1;
   localparam int PD_W   = (PRIORITY_BITS > DEADLINE_BITS) ? PRIORITY_BITS : DEADLINE_BITS;
   localparam int KEY_W  = (PD_W > ARRIVAL_W) ? PD_W : ARRIVAL_W;

   // job table
   logic                     present_ff  [JOB_SLOTS];
   logic                     done_ff     [JOB_SLOTS];
   logic [PRIORITY_BITS-1:0] priority_ff [JOB_SLOTS];
   logic [DEADLINE_BITS-1:0] deadline_ff [JOB_SLOTS];
   logic [ARRIVAL_W-1:0]     arrival_ff  [JOB_SLOTS];
   logic [MASK_W-1:0]        waits_on_ff [JOB_SLOTS];

   logic [ARRIVAL_W-1:0]  arrival_cnt_ff;
   logic [1:0]            order_mode_ff;
   logic [JOB_SLOTS-1:0]  mask_ff, mask_in;
   logic [LIST_CNT_W-1:0] count_ff;
   rsp_data_type          rsp_data_ff, rsp_data_in;

   logic                 slot_ok;
   logic [MASK_W-1:0]    satisfied;
   logic [JOB_SLOTS-1:0] ready_vec;
   logic [JOB_SLOTS-1:0] pick_vec;
   logic [KEY_W-1:0]     entry_key [JOB_SLOTS];

   logic                 node_vld [NODES];
   logic [KEY_W-1:0]     node_key [NODES];
   logic [SLOT_W-1:0]    node_idx [NODES];

   assign slot_ok = (32'(req_data.job_id) < JOB_SLOTS);

   // per-entry storage, write and key select
   for (genvar i = 0; i < JOB_SLOTS; i++) begin : g_entry
      logic                     hit;
      logic [PRIORITY_BITS-1:0] prio_inv;

      assign hit      = slot_ok && (32'(req_data.job_id) == i);
      assign prio_inv = ~priority_ff[i];

      always_ff @(posedge clock) begin
         if (reset) begin
            present_ff[i] <= 1'b0;
            done_ff[i]    <= 1'b0;
         end else if (dp_cmd.add && hit) begin
            present_ff[i] <= 1'b1;
            done_ff[i]    <= 1'b0;
         end else if (dp_cmd.complete && hit && present_ff[i]) begin
            done_ff[i]    <= 1'b1;
         end
      end

      always_ff @(posedge clock) begin
         if (dp_cmd.add && hit) begin
            priority_ff[i] <= PRIORITY_BITS'(req_data.job_priority);
            deadline_ff[i] <= DEADLINE_BITS'(req_data.job_deadline);
            arrival_ff[i]  <= arrival_cnt_ff;
            waits_on_ff[i] <= req_data.depends_on_mask;
         end
      end

      // smaller key goes first; priority is inverted so the largest wins
      always_comb begin
         unique case (order_mode_ff)
            MODE_PRIORITY: entry_key[i] = KEY_W'(prio_inv);
            MODE_DEADLINE: entry_key[i] = KEY_W'(deadline_ff[i]);
            default:       entry_key[i] = KEY_W'(arrival_ff[i]);
         endcase
      end

      assign ready_vec[i] = present_ff[i] && !done_ff[i]
                            && ((waits_on_ff[i] & ~satisfied) == '0);
      assign pick_vec[i]  = node_vld[0] && (node_idx[0] == SLOT_W'(i));
   end

   // a dependency is met only by a present, completed job in range
   for (genvar k = 0; k < MASK_W; k++) begin : g_sat
      if (k < JOB_SLOTS) begin : g_in
         assign satisfied[k] = present_ff[k] && done_ff[k];
      end else begin : g_out
         assign satisfied[k] = 1'b0;
      end
   end

   // selection tree leaves, lower ids on the left
   for (genvar i = 0; i < LEAVES; i++) begin : g_leaf
      if (i < JOB_SLOTS) begin : g_used
         assign node_vld[LEAVES-1+i] = mask_ff[i];
         assign node_key[LEAVES-1+i] = entry_key[i];
         assign node_idx[LEAVES-1+i] = SLOT_W'(i);
      end else begin : g_pad
         assign node_vld[LEAVES-1+i] = 1'b0;
         assign node_key[LEAVES-1+i] = '0;
         assign node_idx[LEAVES-1+i] = '0;
      end
   end

   // inner nodes: right side wins only on a strictly smaller key
   for (genvar n = 0; n < LEAVES - 1; n++) begin : g_node
      logic take_right;
      assign take_right  = node_vld[2*n+2]
                           && (!node_vld[2*n+1] || (node_key[2*n+2] < node_key[2*n+1]));
      assign node_vld[n] = node_vld[2*n+1] || node_vld[2*n+2];
      assign node_key[n] = take_right ? node_key[2*n+2] : node_key[2*n+1];
      assign node_idx[n] = take_right ? node_idx[2*n+2] : node_idx[2*n+1];
   end

   // next list mask and result
   always_comb begin
      mask_in                  = mask_ff & ~pick_vec;
      rsp_data_in.ready_id     = node_vld[0] ? ID_W'(node_idx[0]) : '0;
      rsp_data_in.ready_valid  = node_vld[0];
      rsp_data_in.last_in_list = !node_vld[0] || (mask_in == '0)
                                 || (count_ff == LIST_CNT_W'(LIST_MAX - 1));
   end

   assign dp_status.last = rsp_data_in.last_in_list;
   assign rsp_data       = rsp_data_ff;

   // arrival stamp counter, saturating
   always_ff @(posedge clock) begin
      if (reset) begin
         arrival_cnt_ff <= '0;
      end else if (dp_cmd.add && slot_ok && (arrival_cnt_ff != '1)) begin
         arrival_cnt_ff <= arrival_cnt_ff + 1'b1;
      end
   end

   // order mode register
   always_ff @(posedge clock) begin
      if (reset) begin
         order_mode_ff <= MODE_RESET;
      end else if (csr_we) begin
         order_mode_ff <= csr_wdata;
      end
   end

   // list walk state
   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff  <= '0;
         count_ff <= '0;
      end else if (dp_cmd.load) begin
         mask_ff  <= ready_vec;
         count_ff <= '0;
      end else if (dp_cmd.step) begin
         mask_ff  <= mask_in;
         count_ff <= count_ff + 1'b1;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (dp_cmd.step) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

// ===== rtl/ready_job_dispatch_selector.sv =====
// ready job dispatch selector
// holds a table of jobs indexed by id and lists the jobs that are ready to run
// req channel (valid/ready) carries one command item: add a job, mark a job
// completed or list the ready jobs; rsp channel (valid/ready) returns one
// item per listed job, with last_in_list on the final one, or a single item
// with ready_valid low when nothing is ready
// csr_we/csr_wdata write the order mode (arrival, priority or deadline)
// add and complete leave the input open; the next item is taken in the next cycle
// a list first snapshots the ready set into a mask register, then emits the
// results one at a time through the result register; each result comes from
// one pass through a compare tree over all slots, so the tree depth of
// log2(JOB_SLOTS) compares sets the clock path
// no new item is taken while a list is being emitted
// a stalled receiver holds the current result; the walk waits with it
// reset empties the table, clears the arrival counter and sets priority order
module ready_job_dispatch_selector
   import rjds_pkg::*;
#(
   parameter int JOB_SLOTS     = 16,
   parameter int PRIORITY_BITS = 8,
   parameter int DEADLINE_BITS = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_data_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_data_type rsp_data,
   input  logic         csr_we,
   input  logic [1:0]   csr_wdata
);

   dp_cmd_type    dp_cmd;
   dp_status_type dp_status;

   // sequencer
   rjds_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_opcode (req_data.opcode),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .dp_cmd     (dp_cmd),
      .dp_status  (dp_status)
   );

   // job table and selection
   rjds_datapath #(
      .JOB_SLOTS     (JOB_SLOTS),
      .PRIORITY_BITS (PRIORITY_BITS),
      .DEADLINE_BITS (DEADLINE_BITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .dp_cmd    (dp_cmd),
      .dp_status (dp_status),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== rtl/rjds_checker.sv =====
module rjds_checker
   import rjds_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         req_valid,
   input logic         req_ready,
   input req_data_type req_data,
   input logic         rsp_valid,
   input logic         rsp_ready,
   input rsp_data_type rsp_data
);

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   // an empty result always closes its list
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.ready_valid |-> rsp_data.last_in_list)
      else $error("empty result without last flag");

   // an accepted list blocks new items
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_data.opcode == OP_LIST) |=> !req_ready)
      else $error("item taken right after list");

   // while a mid-list result is offered the input stays closed
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.last_in_list |-> !req_ready)
      else $error("item taken inside a list");

endmodule

bind ready_job_dispatch_selector rjds_checker u_rjds_checker (.*);
